### rtl/core/pm0_pkg.sv
// Shared types, opcodes and defaults for the PM/0 execute core.
// No dependencies; used by every file under rtl/core but pm0_md.
package pm0_pkg;

  localparam int MemWordsDef   = 512;
  localparam int WordBitsDef   = 32;
  localparam int MaxLevelDef   = 7;
  localparam int InitSpReset   = 500;
  localparam int WordsPerInstr = 3;
  localparam int InDataBits    = 72;
  localparam int OutDataBits   = 96;

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  localparam logic [31:0] OPR_RET = 32'd0;
  localparam logic [31:0] OPR_ADD = 32'd1;
  localparam logic [31:0] OPR_SUB = 32'd2;
  localparam logic [31:0] OPR_MUL = 32'd3;
  localparam logic [31:0] OPR_DIV = 32'd4;
  localparam logic [31:0] OPR_EQL = 32'd5;
  localparam logic [31:0] OPR_NEQ = 32'd6;
  localparam logic [31:0] OPR_LSS = 32'd7;
  localparam logic [31:0] OPR_LEQ = 32'd8;
  localparam logic [31:0] OPR_GTR = 32'd9;
  localparam logic [31:0] OPR_GEQ = 32'd10;

  localparam logic [31:0] SYS_OUT  = 32'd1;
  localparam logic [31:0] SYS_IN   = 32'd2;
  localparam logic [31:0] SYS_HALT = 32'd3;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_DIV0, ERR_RANGE, ERR_OPCODE
  } err_e;

  typedef enum logic [1:0] {
    RD_LINK, RD_FIRST, RD_SECOND, RD_TOP
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_LINK, ST_LINK_WAIT, ST_POST,
    ST_RD1, ST_RD1_WAIT, ST_RD2, ST_RD2_WAIT, ST_CHECK, ST_MD,
    ST_WRITE, ST_COMMIT, ST_TOP, ST_TOP_WAIT
  } state_e;

  typedef struct packed {
    logic       clr_wr;
    logic       load;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       ld_a;
    logic       ld_b;
    logic       link_init;
    logic       link_step;
    logic       md_start;
    logic       wr_en;
    logic [1:0] wr_step;
    logic       commit;
    logic       set_err;
    err_e       err;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       halted;
    logic       bad_op;
    logic       pre_bad;
    logic       needs_link;
    logic       lev_zero;
    logic       link_bad;
    logic       post_bad;
    logic [1:0] n_reads;
    logic       final_bad;
    err_e       final_err;
    logic       needs_md;
    logic       md_done;
    logic [1:0] n_writes;
  } status_t;

endpackage

### rtl/core/pm0_md.sv
// Iterative multiply / signed divide unit, one bit per cycle.
// Depends on nothing but its parameter; used by pm0_dpath.
module pm0_md #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 div_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] res_o
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic          busy_q, div_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q, y_q, acc_q, quo_q;
  logic [W:0]    rsh, rdiff;

  assign rsh   = {acc_q, x_q[W-1]};
  assign rdiff = rsh - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
      quo_q <= '0;
      if (div_i) begin
        x_q <= a_i[W-1] ? -a_i : a_i;
        y_q <= b_i[W-1] ? -b_i : b_i;
      end else begin
        x_q <= a_i;
        y_q <= b_i;
      end
    end else if (busy_q && cnt_q != '0) begin
      x_q <= {x_q[W-2:0], 1'b0};
      if (div_q) begin
        if (!rdiff[W]) begin
          acc_q <= rdiff[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          acc_q <= rsh[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
      end else begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        y_q <= {1'b0, y_q[W-1:1]};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign res_o  = div_q ? (neg_q ? -quo_q : quo_q) : acc_q;

endmodule

### rtl/core/pm0_dpath.sv
// Datapath: word memory, PC/BP/SP, instruction and operand registers, checks.
// Depends on pm0_pkg and pm0_md; driven by pm0_ctrl through cmd_t/status_t.
module pm0_dpath #(
  parameter int MEM_WORDS = pm0_pkg::MemWordsDef,
  parameter int WORD_BITS = pm0_pkg::WordBitsDef,
  parameter int MAX_LEVEL = pm0_pkg::MaxLevelDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        opcode_i,
  input  logic [2:0]        level_i,
  input  logic [31:0]       operand_m_i,
  input  logic [31:0]       read_value_i,
  input  logic              cfg_we_i,
  input  logic [9:0]        cfg_data_i,
  input  pm0_pkg::cmd_t     cmd_i,
  output pm0_pkg::status_t  status_o,
  output logic [8:0]        next_pc_o,
  output logic [8:0]        base_pointer_o,
  output logic [9:0]        stack_pointer_o,
  output logic [31:0]       top_value_o,
  output logic              output_valid_o,
  output logic [31:0]       output_value_o,
  output logic              halted_o,
  output logic [1:0]        error_code_o
);

  localparam int W  = WORD_BITS;
  localparam int AW = $clog2(MEM_WORDS);
  localparam int SW = $clog2(MEM_WORDS + 1);
  localparam int XW = 34;
  localparam int CW = W + 16;
  localparam int ResetSp = (pm0_pkg::InitSpReset > MEM_WORDS) ? MEM_WORDS
                                                               : pm0_pkg::InitSpReset;

  logic [SW-1:0] sp_q;
  logic [AW-1:0] bp_q, pc_q, base_q, clr_q;
  logic          halt_q, ov_q;
  pm0_pkg::err_e err_q;
  logic [3:0]    op_q;
  logic [2:0]    lev_q, cnt_q;
  logic [31:0]   m_q, rv_q;
  logic [W-1:0]  a_q, b_q, rdata_q;
  logic [W-1:0]  mem_q [MEM_WORDS];

  logic [SW-1:0] cfg_sp;
  logic [AW-1:0] pc_s, npc, raddr, waddr;
  logic [W-1:0]  wdata, alu_res, md_res, mw, rw;
  logic [XW-1:0] addr_x, inc_x, m_x;
  logic          addr_ok, inc_ok, tgt_ok, md_done;
  logic          is_ret, is_alu, is_mul, is_div, is_out, is_in, is_halt;
  logic          sp_zero, sp_over, sp_full, spp1_bad, sp_lt3;
  logic          a_big, b_big, link_bad;

  assign mw = W'($signed(m_q));
  assign rw = W'($signed(rv_q));

  assign is_ret  = (op_q == pm0_pkg::OP_OPR) && (m_q == pm0_pkg::OPR_RET);
  assign is_alu  = (op_q == pm0_pkg::OP_OPR) && ($signed(m_q) >= 1) && ($signed(m_q) <= 10);
  assign is_mul  = is_alu && (m_q == pm0_pkg::OPR_MUL);
  assign is_div  = is_alu && (m_q == pm0_pkg::OPR_DIV);
  assign is_out  = (op_q == pm0_pkg::OP_SYS) && (m_q == pm0_pkg::SYS_OUT);
  assign is_in   = (op_q == pm0_pkg::OP_SYS) && (m_q == pm0_pkg::SYS_IN);
  assign is_halt = (op_q == pm0_pkg::OP_SYS) && (m_q == pm0_pkg::SYS_HALT);

  assign sp_zero  = (sp_q == '0);
  assign sp_over  = (sp_q > SW'(MEM_WORDS));
  assign sp_full  = (sp_q >= SW'(MEM_WORDS));
  assign spp1_bad = ((SW+1)'(sp_q) + (SW+1)'(1)) >= (SW+1)'(MEM_WORDS);
  assign sp_lt3   = (sp_q < SW'(3));

  assign m_x     = {{(XW-32){m_q[31]}}, m_q};
  assign addr_x  = XW'(base_q) - m_x;
  assign inc_x   = XW'(sp_q) - m_x;
  assign addr_ok = !addr_x[XW-1] && (addr_x[XW-2:0] < (XW-1)'(MEM_WORDS));
  assign inc_ok  = !inc_x[XW-1] && (inc_x[XW-2:0] <= (XW-1)'(MEM_WORDS));
  assign tgt_ok  = !m_q[31] && (m_q < 32'(MEM_WORDS));
  assign npc     = AW'(32'(MEM_WORDS - 1) - m_q);

  assign pc_s = (pc_q >= AW'(pm0_pkg::WordsPerInstr)) ?
                pc_q - AW'(pm0_pkg::WordsPerInstr) :
                pc_q + AW'(MEM_WORDS - pm0_pkg::WordsPerInstr);

  assign a_big    = CW'(a_q) >= CW'(MEM_WORDS);
  assign b_big    = CW'(b_q) >= CW'(MEM_WORDS);
  assign link_bad = CW'(rdata_q) >= CW'(MEM_WORDS);

  assign cfg_sp = (int'(cfg_data_i) > MEM_WORDS) ? SW'(MEM_WORDS) : SW'(cfg_data_i);

  pm0_md #(.WORD_BITS(W)) u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.md_start),
    .div_i  (is_div),
    .a_i    (a_q),
    .b_i    (b_q),
    .done_o (md_done),
    .res_o  (md_res)
  );

  always_comb begin
    status_o            = '0;
    status_o.clr_last   = (clr_q == AW'(MEM_WORDS - 1));
    status_o.halted     = halt_q;
    status_o.bad_op     = (op_q == 4'd0) || (op_q > pm0_pkg::OP_SYS);
    status_o.lev_zero   = (cnt_q == '0);
    status_o.link_bad   = link_bad;
    status_o.md_done    = md_done;
    status_o.needs_md   = is_mul || is_div;
    status_o.final_err  = pm0_pkg::ERR_RANGE;
    case (op_q)
      pm0_pkg::OP_LIT: begin
        status_o.pre_bad  = sp_zero || sp_over;
        status_o.n_writes = 2'd1;
      end
      pm0_pkg::OP_OPR: begin
        if (is_ret) begin
          status_o.pre_bad   = (bp_q < AW'(2));
          status_o.n_reads   = 2'd2;
          status_o.final_bad = a_big || b_big;
        end else if (is_alu) begin
          status_o.pre_bad   = spp1_bad;
          status_o.n_reads   = 2'd2;
          status_o.n_writes  = 2'd1;
          status_o.final_bad = is_div && (b_q == '0);
          status_o.final_err = pm0_pkg::ERR_DIV0;
        end
      end
      pm0_pkg::OP_LOD: begin
        status_o.pre_bad    = int'(lev_q) > MAX_LEVEL;
        status_o.needs_link = 1'b1;
        status_o.post_bad   = !addr_ok || sp_zero || sp_over;
        status_o.n_reads    = 2'd1;
        status_o.n_writes   = 2'd1;
      end
      pm0_pkg::OP_STO: begin
        status_o.pre_bad    = int'(lev_q) > MAX_LEVEL;
        status_o.needs_link = 1'b1;
        status_o.post_bad   = !addr_ok || sp_full;
        status_o.n_reads    = 2'd1;
        status_o.n_writes   = 2'd1;
      end
      pm0_pkg::OP_CAL: begin
        status_o.pre_bad    = int'(lev_q) > MAX_LEVEL;
        status_o.needs_link = 1'b1;
        status_o.post_bad   = sp_lt3 || sp_over || !tgt_ok;
        status_o.n_writes   = 2'd3;
      end
      pm0_pkg::OP_INC: status_o.pre_bad = !inc_ok;
      pm0_pkg::OP_JMP: status_o.pre_bad = !tgt_ok;
      pm0_pkg::OP_JPC: begin
        status_o.pre_bad   = sp_full;
        status_o.n_reads   = 2'd1;
        status_o.final_bad = (a_q == '0) && !tgt_ok;
      end
      pm0_pkg::OP_SYS: begin
        if (is_out) begin
          status_o.pre_bad = sp_full;
          status_o.n_reads = 2'd1;
        end else if (is_in) begin
          status_o.pre_bad  = sp_zero || sp_over;
          status_o.n_writes = 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (m_q)
      pm0_pkg::OPR_ADD: alu_res = a_q + b_q;
      pm0_pkg::OPR_SUB: alu_res = a_q - b_q;
      pm0_pkg::OPR_MUL: alu_res = md_res;
      pm0_pkg::OPR_DIV: alu_res = md_res;
      pm0_pkg::OPR_EQL: alu_res = W'(a_q == b_q);
      pm0_pkg::OPR_NEQ: alu_res = W'(a_q != b_q);
      pm0_pkg::OPR_LSS: alu_res = W'($signed(a_q) < $signed(b_q));
      pm0_pkg::OPR_LEQ: alu_res = W'(!($signed(b_q) < $signed(a_q)));
      pm0_pkg::OPR_GTR: alu_res = W'($signed(b_q) < $signed(a_q));
      pm0_pkg::OPR_GEQ: alu_res = W'(!($signed(a_q) < $signed(b_q)));
      default:          alu_res = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      pm0_pkg::RD_LINK: raddr = base_q;
      pm0_pkg::RD_FIRST: begin
        if (is_ret) begin
          raddr = bp_q - AW'(1);
        end else if (is_alu) begin
          raddr = AW'(sp_q + SW'(1));
        end else if (op_q == pm0_pkg::OP_LOD) begin
          raddr = AW'(addr_x);
        end else begin
          raddr = AW'(sp_q);
        end
      end
      pm0_pkg::RD_SECOND: raddr = is_ret ? bp_q - AW'(2) : AW'(sp_q);
      default: raddr = AW'(sp_q);
    endcase
  end

  always_comb begin
    waddr = AW'(sp_q - SW'(1));
    wdata = mw;
    if (cmd_i.clr_wr) begin
      waddr = clr_q;
      wdata = '0;
    end else begin
      case (op_q)
        pm0_pkg::OP_OPR: begin
          waddr = AW'(sp_q + SW'(1));
          wdata = alu_res;
        end
        pm0_pkg::OP_LOD: wdata = a_q;
        pm0_pkg::OP_STO: begin
          waddr = AW'(addr_x);
          wdata = a_q;
        end
        pm0_pkg::OP_CAL: begin
          case (cmd_i.wr_step)
            2'd0: wdata = W'(base_q);
            2'd1: begin
              waddr = AW'(sp_q - SW'(2));
              wdata = W'(bp_q);
            end
            default: begin
              waddr = AW'(sp_q - SW'(3));
              wdata = W'(pc_s);
            end
          endcase
        end
        pm0_pkg::OP_SYS: wdata = rw;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en || cmd_i.clr_wr) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      lev_q <= level_i;
      m_q   <= operand_m_i;
      rv_q  <= read_value_i;
    end
    if (cmd_i.ld_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.ld_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.link_init) begin
      base_q <= bp_q;
      cnt_q  <= lev_q;
    end else if (cmd_i.link_step) begin
      base_q <= AW'(rdata_q);
      cnt_q  <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= SW'(ResetSp);
      bp_q   <= (ResetSp == 0) ? '0 : AW'(ResetSp - 1);
      pc_q   <= AW'(MEM_WORDS - 1);
      halt_q <= 1'b0;
      err_q  <= pm0_pkg::ERR_NONE;
      ov_q   <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load) begin
        ov_q <= 1'b0;
      end
      if (cfg_we_i) begin
        sp_q   <= cfg_sp;
        bp_q   <= (cfg_sp == '0) ? '0 : AW'(cfg_sp - SW'(1));
        pc_q   <= AW'(MEM_WORDS - 1);
        halt_q <= 1'b0;
        err_q  <= pm0_pkg::ERR_NONE;
      end else if (cmd_i.set_err) begin
        halt_q <= 1'b1;
        err_q  <= cmd_i.err;
      end else if (cmd_i.commit) begin
        pc_q <= pc_s;
        case (op_q)
          pm0_pkg::OP_LIT, pm0_pkg::OP_LOD: sp_q <= sp_q - SW'(1);
          pm0_pkg::OP_OPR: begin
            if (is_ret) begin
              sp_q <= SW'(bp_q) + SW'(1);
              bp_q <= AW'(a_q);
              pc_q <= AW'(b_q);
            end else if (is_alu) begin
              sp_q <= sp_q + SW'(1);
            end
          end
          pm0_pkg::OP_STO: sp_q <= sp_q + SW'(1);
          pm0_pkg::OP_CAL: begin
            bp_q <= AW'(sp_q - SW'(1));
            pc_q <= npc;
          end
          pm0_pkg::OP_INC: sp_q <= SW'(inc_x);
          pm0_pkg::OP_JMP: pc_q <= npc;
          pm0_pkg::OP_JPC: begin
            sp_q <= sp_q + SW'(1);
            if (a_q == '0) begin
              pc_q <= npc;
            end
          end
          pm0_pkg::OP_SYS: begin
            if (is_out) begin
              sp_q <= sp_q + SW'(1);
              ov_q <= 1'b1;
            end else if (is_in) begin
              sp_q <= sp_q - SW'(1);
            end else if (is_halt) begin
              halt_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      next_pc_o       <= 9'(pc_q);
      base_pointer_o  <= 9'(bp_q);
      stack_pointer_o <= 10'(sp_q);
      top_value_o     <= sp_full ? 32'd0 : 32'($signed(rdata_q));
      output_valid_o  <= ov_q;
      output_value_o  <= ov_q ? 32'($signed(a_q)) : 32'd0;
      halted_o        <= halt_q;
      error_code_o    <= err_q;
    end
  end

endmodule

### rtl/core/pm0_ctrl.sv
// Sequencer FSM for the PM/0 execute core: clear pass, decode, link walk,
// reads, checks, mul/div wait, writes, commit, result. Depends on pm0_pkg.
module pm0_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pm0_pkg::status_t  status_i,
  output pm0_pkg::cmd_t     cmd_o
);

  pm0_pkg::state_e state_q, state_d;
  logic [1:0]      wcnt_q, wcnt_d;
  logic            ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pm0_pkg::ST_CLEAR;
      wcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    ov_d       = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    case (state_q)
      pm0_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = pm0_pkg::ST_IDLE;
        end
      end
      pm0_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pm0_pkg::ST_DECODE;
        end
      end
      pm0_pkg::ST_DECODE: begin
        if (status_i.halted) begin
          state_d = pm0_pkg::ST_TOP;
        end else if (status_i.bad_op) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = pm0_pkg::ERR_OPCODE;
          state_d       = pm0_pkg::ST_TOP;
        end else if (status_i.pre_bad) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = pm0_pkg::ERR_RANGE;
          state_d       = pm0_pkg::ST_TOP;
        end else if (status_i.needs_link) begin
          cmd_o.link_init = 1'b1;
          state_d         = pm0_pkg::ST_LINK;
        end else begin
          state_d = pm0_pkg::ST_POST;
        end
      end
      pm0_pkg::ST_LINK: begin
        if (status_i.lev_zero) begin
          state_d = pm0_pkg::ST_POST;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = pm0_pkg::RD_LINK;
          state_d      = pm0_pkg::ST_LINK_WAIT;
        end
      end
      pm0_pkg::ST_LINK_WAIT: begin
        if (status_i.link_bad) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = pm0_pkg::ERR_RANGE;
          state_d       = pm0_pkg::ST_TOP;
        end else begin
          cmd_o.link_step = 1'b1;
          state_d         = pm0_pkg::ST_LINK;
        end
      end
      pm0_pkg::ST_POST: begin
        if (status_i.post_bad) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = pm0_pkg::ERR_RANGE;
          state_d       = pm0_pkg::ST_TOP;
        end else if (status_i.n_reads != 2'd0) begin
          state_d = pm0_pkg::ST_RD1;
        end else begin
          state_d = pm0_pkg::ST_CHECK;
        end
      end
      pm0_pkg::ST_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pm0_pkg::RD_FIRST;
        state_d      = pm0_pkg::ST_RD1_WAIT;
      end
      pm0_pkg::ST_RD1_WAIT: begin
        cmd_o.ld_a = 1'b1;
        state_d    = (status_i.n_reads == 2'd2) ? pm0_pkg::ST_RD2 : pm0_pkg::ST_CHECK;
      end
      pm0_pkg::ST_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pm0_pkg::RD_SECOND;
        state_d      = pm0_pkg::ST_RD2_WAIT;
      end
      pm0_pkg::ST_RD2_WAIT: begin
        cmd_o.ld_b = 1'b1;
        state_d    = pm0_pkg::ST_CHECK;
      end
      pm0_pkg::ST_CHECK: begin
        wcnt_d = '0;
        if (status_i.final_bad) begin
          cmd_o.set_err = 1'b1;
          cmd_o.err     = status_i.final_err;
          state_d       = pm0_pkg::ST_TOP;
        end else if (status_i.needs_md) begin
          cmd_o.md_start = 1'b1;
          state_d        = pm0_pkg::ST_MD;
        end else if (status_i.n_writes != 2'd0) begin
          state_d = pm0_pkg::ST_WRITE;
        end else begin
          state_d = pm0_pkg::ST_COMMIT;
        end
      end
      pm0_pkg::ST_MD: begin
        if (status_i.md_done) begin
          state_d = pm0_pkg::ST_WRITE;
        end
      end
      pm0_pkg::ST_WRITE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_step = wcnt_q;
        if (wcnt_q == status_i.n_writes - 2'd1) begin
          state_d = pm0_pkg::ST_COMMIT;
        end else begin
          wcnt_d = wcnt_q + 2'd1;
        end
      end
      pm0_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = pm0_pkg::ST_TOP;
      end
      pm0_pkg::ST_TOP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pm0_pkg::RD_TOP;
        state_d      = pm0_pkg::ST_TOP_WAIT;
      end
      pm0_pkg::ST_TOP_WAIT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d           = 1'b1;
          state_d        = pm0_pkg::ST_IDLE;
        end
      end
      default: state_d = pm0_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

### rtl/core/pm0_stack_machine_execute_core.sv
// Top level of the PM/0 execute core: stream ports, controller and datapath.
// Depends on pm0_pkg, pm0_ctrl, pm0_dpath (and pm0_md below it).
//
//  channel | direction | handshake                    | payload
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | one instruction
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | machine state after it
//  cfg     | in        | cfg_valid_i/cfg_ready_o      | initial stack pointer
//
// One instruction per transfer; each static level walked adds a link read.
// A halted core or a fault at decode goes straight to the result read.
// MUL and DIV wait on the shift-add / shift-subtract unit. Every step is
// bound by the single-port word memory with registered read data.
// After reset a clearing pass writes MEM_WORDS zero words.
// A finished result sits in the output register while the next item is taken.
module pm0_stack_machine_execute_core #(
  parameter int MEM_WORDS = pm0_pkg::MemWordsDef,
  parameter int WORD_BITS = pm0_pkg::WordBitsDef,
  parameter int MAX_LEVEL = pm0_pkg::MaxLevelDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // opcode[3:0], level[6:4], operand_m[38:7], read_value[70:39], zero pad[71]
  input  logic [pm0_pkg::InDataBits-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // next_pc[8:0], base_pointer[17:9], stack_pointer[27:18], top_value[59:28],
  // output_valid[60], output_value[92:61], halted[93], error_code[95:94]
  output logic [pm0_pkg::OutDataBits-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [9:0]                        cfg_data_i
);

  pm0_pkg::cmd_t    cmd;
  pm0_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pm0_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pm0_dpath #(
    .MEM_WORDS(MEM_WORDS),
    .WORD_BITS(WORD_BITS),
    .MAX_LEVEL(MAX_LEVEL)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (s_axis_tdata[3:0]),
    .level_i        (s_axis_tdata[6:4]),
    .operand_m_i    (s_axis_tdata[38:7]),
    .read_value_i   (s_axis_tdata[70:39]),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .next_pc_o      (m_axis_tdata[8:0]),
    .base_pointer_o (m_axis_tdata[17:9]),
    .stack_pointer_o(m_axis_tdata[27:18]),
    .top_value_o    (m_axis_tdata[59:28]),
    .output_valid_o (m_axis_tdata[60]),
    .output_value_o (m_axis_tdata[92:61]),
    .halted_o       (m_axis_tdata[93]),
    .error_code_o   (m_axis_tdata[95:94])
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[93] |-> m_axis_tdata[95:94] == 2'd0)
    else $error("error code without halt");

  a_out_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[60] |-> !m_axis_tdata[93])
    else $error("output value from a halted machine");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten before transfer");

endmodule
